// File: sv/pnfe_pkg.sv
// Shared definitions of the Petri net firing engine: sizes, command kinds,
// status codes, configuration indices, controller states and the controller/datapath structs.
// No dependencies.
package pnfe_pkg;

    localparam int MAX_PLACES = 32;
    localparam int MAX_TRANS  = 32;
    localparam int ARC_SLOTS  = 8;

    localparam int PW    = $clog2(MAX_PLACES);
    localparam int TW    = $clog2(MAX_TRANS);
    localparam int SW    = $clog2(ARC_SLOTS);
    localparam int FW    = SW + 1;
    localparam int AW    = TW + SW;
    localparam int ARC_DEPTH = MAX_TRANS * ARC_SLOTS;
    localparam int TOK_W = 16;
    localparam int DEM_W = TOK_W + AW;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_COND   = 2'd1;
    localparam logic [1:0] ST_TOKENS = 2'd2;
    localparam logic [1:0] ST_RANGE  = 2'd3;

    localparam logic [2:0] CFG_COND_EN   = 3'd0;
    localparam logic [2:0] CFG_PLACES    = 3'd1;
    localparam logic [2:0] CFG_TRANS     = 3'd2;
    localparam logic [2:0] CFG_IN_ARCS   = 3'd3;
    localparam logic [2:0] CFG_OUT_ARCS  = 3'd4;

    typedef enum logic [3:0] {
        KIND_CLEAR     = 4'd0,
        KIND_ADD_ARC   = 4'd1,
        KIND_TOKENS    = 4'd2,
        KIND_COND      = 4'd3,
        KIND_QTY       = 4'd4,
        KIND_FIRE_VEC  = 4'd5,
        KIND_CHECK_VEC = 4'd6,
        KIND_FIRE_ONE  = 4'd7,
        KIND_CHECK_ONE = 4'd8,
        KIND_READ      = 4'd9
    } kind_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_COND,
        S_ARC_ISSUE,
        S_ARC_ACC,
        S_TCHK,
        S_SUB,
        S_OUT_ISSUE,
        S_OUT_ACC,
        S_ADD_ISSUE,
        S_ADD_CMP,
        S_DONE
    } state_t;

    typedef struct packed {
        logic       load;
        logic       clr_fill;
        logic       wr_simple;
        logic       rd_tok;
        logic       t_init;
        logic       t_inc;
        logic       s_clr;
        logic       s_inc;
        logic       p_clr;
        logic       p_inc;
        logic       clr_demand;
        logic       rd_in;
        logic       rd_out;
        logic       acc_demand;
        logic       sub_tok;
        logic       add_tok;
        logic       wr_arc;
        logic       set_status;
        logic [1:0] status;
        logic       emit;
    } cmd_t;

    typedef struct packed {
        kind_t kind;
        logic  t_ok;
        logic  p_ok;
        logic  to_out;
        logic  commit;
        logic  cond_bad;
        logic  q_zero;
        logic  t_last;
        logic  in_end;
        logic  out_end;
        logic  sel_end;
        logic  sel_full;
        logic  dup;
        logic  tok_short;
        logic  p_last;
        logic  out_busy;
    } stat_t;

endpackage

// File: sv/pnfe_ctrl.sv
// Controller of the Petri net firing engine: sequences each request through
// its phases. Depends on pnfe_pkg.
module pnfe_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  pnfe_pkg::stat_t  stat,
    output pnfe_pkg::cmd_t   cmd
);

    pnfe_pkg::state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= pnfe_pkg::S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_ready = (state_reg == pnfe_pkg::S_IDLE);

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            pnfe_pkg::S_IDLE: begin
                if (s_valid) state_next = pnfe_pkg::S_DISPATCH;
            end
            pnfe_pkg::S_DISPATCH: begin
                case (stat.kind)
                    pnfe_pkg::KIND_ADD_ARC:
                        state_next = (stat.t_ok && stat.p_ok) ? pnfe_pkg::S_ADD_ISSUE
                                                              : pnfe_pkg::S_DONE;
                    pnfe_pkg::KIND_FIRE_VEC, pnfe_pkg::KIND_CHECK_VEC:
                        state_next = pnfe_pkg::S_COND;
                    pnfe_pkg::KIND_FIRE_ONE, pnfe_pkg::KIND_CHECK_ONE:
                        state_next = stat.t_ok ? pnfe_pkg::S_COND : pnfe_pkg::S_DONE;
                    default: state_next = pnfe_pkg::S_DONE;
                endcase
            end
            pnfe_pkg::S_COND: begin
                if (stat.cond_bad) state_next = pnfe_pkg::S_DONE;
                else if (stat.t_last) state_next = pnfe_pkg::S_ARC_ISSUE;
            end
            pnfe_pkg::S_ARC_ISSUE: begin
                if (stat.q_zero || stat.in_end) begin
                    if (stat.t_last) state_next = pnfe_pkg::S_TCHK;
                end else begin
                    state_next = pnfe_pkg::S_ARC_ACC;
                end
            end
            pnfe_pkg::S_ARC_ACC: state_next = pnfe_pkg::S_ARC_ISSUE;
            pnfe_pkg::S_TCHK: begin
                if (stat.tok_short) state_next = pnfe_pkg::S_DONE;
                else if (stat.p_last)
                    state_next = stat.commit ? pnfe_pkg::S_SUB : pnfe_pkg::S_DONE;
            end
            pnfe_pkg::S_SUB: begin
                if (stat.p_last) state_next = pnfe_pkg::S_OUT_ISSUE;
            end
            pnfe_pkg::S_OUT_ISSUE: begin
                if (stat.q_zero || stat.out_end) begin
                    if (stat.t_last) state_next = pnfe_pkg::S_DONE;
                end else begin
                    state_next = pnfe_pkg::S_OUT_ACC;
                end
            end
            pnfe_pkg::S_OUT_ACC: state_next = pnfe_pkg::S_OUT_ISSUE;
            pnfe_pkg::S_ADD_ISSUE: begin
                state_next = stat.sel_end ? pnfe_pkg::S_DONE : pnfe_pkg::S_ADD_CMP;
            end
            pnfe_pkg::S_ADD_CMP: begin
                state_next = stat.dup ? pnfe_pkg::S_DONE : pnfe_pkg::S_ADD_ISSUE;
            end
            pnfe_pkg::S_DONE: begin
                if (!stat.out_busy) state_next = pnfe_pkg::S_IDLE;
            end
            default: state_next = pnfe_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        cmd = '0;
        case (state_reg)
            pnfe_pkg::S_IDLE: begin
                cmd.load = s_valid;
            end
            pnfe_pkg::S_DISPATCH: begin
                cmd.set_status = 1'b1;
                cmd.status     = pnfe_pkg::ST_OK;
                case (stat.kind)
                    pnfe_pkg::KIND_CLEAR: cmd.clr_fill = 1'b1;
                    pnfe_pkg::KIND_ADD_ARC: begin
                        cmd.t_init = 1'b1;
                        cmd.s_clr  = 1'b1;
                        if (!(stat.t_ok && stat.p_ok)) cmd.status = pnfe_pkg::ST_RANGE;
                    end
                    pnfe_pkg::KIND_TOKENS: begin
                        cmd.wr_simple = 1'b1;
                        if (!stat.p_ok) cmd.status = pnfe_pkg::ST_RANGE;
                    end
                    pnfe_pkg::KIND_COND, pnfe_pkg::KIND_QTY: begin
                        cmd.wr_simple = 1'b1;
                        if (!stat.t_ok) cmd.status = pnfe_pkg::ST_RANGE;
                    end
                    pnfe_pkg::KIND_FIRE_VEC, pnfe_pkg::KIND_CHECK_VEC: begin
                        cmd.t_init = 1'b1;
                    end
                    pnfe_pkg::KIND_FIRE_ONE, pnfe_pkg::KIND_CHECK_ONE: begin
                        cmd.t_init = 1'b1;
                        if (!stat.t_ok) cmd.status = pnfe_pkg::ST_RANGE;
                    end
                    pnfe_pkg::KIND_READ: begin
                        cmd.rd_tok = 1'b1;
                        if (!stat.p_ok) cmd.status = pnfe_pkg::ST_RANGE;
                    end
                    default: cmd.status = pnfe_pkg::ST_RANGE;
                endcase
            end
            pnfe_pkg::S_COND: begin
                if (stat.cond_bad) begin
                    cmd.set_status = 1'b1;
                    cmd.status     = pnfe_pkg::ST_COND;
                end else if (stat.t_last) begin
                    cmd.t_init     = 1'b1;
                    cmd.s_clr      = 1'b1;
                    cmd.clr_demand = 1'b1;
                end else begin
                    cmd.t_inc = 1'b1;
                end
            end
            pnfe_pkg::S_ARC_ISSUE: begin
                if (stat.q_zero || stat.in_end) begin
                    if (stat.t_last) begin
                        cmd.p_clr = 1'b1;
                    end else begin
                        cmd.t_inc = 1'b1;
                        cmd.s_clr = 1'b1;
                    end
                end else begin
                    cmd.rd_in = 1'b1;
                end
            end
            pnfe_pkg::S_ARC_ACC: begin
                cmd.acc_demand = 1'b1;
                cmd.s_inc      = 1'b1;
            end
            pnfe_pkg::S_TCHK: begin
                if (stat.tok_short) begin
                    cmd.set_status = 1'b1;
                    cmd.status     = pnfe_pkg::ST_TOKENS;
                end else if (stat.p_last) begin
                    cmd.p_clr = 1'b1;
                end else begin
                    cmd.p_inc = 1'b1;
                end
            end
            pnfe_pkg::S_SUB: begin
                cmd.sub_tok = 1'b1;
                if (stat.p_last) begin
                    cmd.t_init = 1'b1;
                    cmd.s_clr  = 1'b1;
                end else begin
                    cmd.p_inc = 1'b1;
                end
            end
            pnfe_pkg::S_OUT_ISSUE: begin
                if (stat.q_zero || stat.out_end) begin
                    if (!stat.t_last) begin
                        cmd.t_inc = 1'b1;
                        cmd.s_clr = 1'b1;
                    end
                end else begin
                    cmd.rd_out = 1'b1;
                end
            end
            pnfe_pkg::S_OUT_ACC: begin
                cmd.add_tok = 1'b1;
                cmd.s_inc   = 1'b1;
            end
            pnfe_pkg::S_ADD_ISSUE: begin
                if (stat.sel_end) begin
                    cmd.set_status = 1'b1;
                    if (stat.sel_full) begin
                        cmd.status = pnfe_pkg::ST_RANGE;
                    end else begin
                        cmd.status = pnfe_pkg::ST_OK;
                        cmd.wr_arc = 1'b1;
                    end
                end else if (stat.to_out) begin
                    cmd.rd_out = 1'b1;
                end else begin
                    cmd.rd_in = 1'b1;
                end
            end
            pnfe_pkg::S_ADD_CMP: begin
                if (stat.dup) begin
                    cmd.set_status = 1'b1;
                    cmd.status     = pnfe_pkg::ST_RANGE;
                end else begin
                    cmd.s_inc = 1'b1;
                end
            end
            pnfe_pkg::S_DONE: begin
                cmd.emit = !stat.out_busy;
            end
            default: cmd = '0;
        endcase
    end

endmodule

// File: sv/pnfe_dp.sv
// Datapath of the Petri net firing engine: configuration, token and quantity
// stores, arc memories, demand accumulators, loop counters and the result
// register. Depends on pnfe_pkg.
module pnfe_dp (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [2:0]                   cfg_index,
    input  logic [15:0]                  cfg_data,
    input  logic [3:0]                   s_kind,
    input  logic [pnfe_pkg::TW-1:0]      s_transition,
    input  logic [pnfe_pkg::PW-1:0]      s_place,
    input  logic                         s_to_output,
    input  logic [pnfe_pkg::TOK_W-1:0]   s_value,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [1:0]                   m_status,
    output logic [pnfe_pkg::TOK_W-1:0]   m_token_count,
    input  pnfe_pkg::cmd_t               cmd,
    output pnfe_pkg::stat_t              stat
);

    // configuration
    logic       cen_reg;
    logic [5:0] pcount_reg, tcount_reg;
    logic [3:0] max_in_reg, max_out_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cen_reg     <= 1'b0;
            pcount_reg  <= 6'd32;
            tcount_reg  <= 6'd32;
            max_in_reg  <= 4'd8;
            max_out_reg <= 4'd8;
        end else if (cfg_valid) begin
            case (cfg_index)
                pnfe_pkg::CFG_COND_EN:  cen_reg     <= cfg_data[0];
                pnfe_pkg::CFG_PLACES:   pcount_reg  <= cfg_data[5:0];
                pnfe_pkg::CFG_TRANS:    tcount_reg  <= cfg_data[5:0];
                pnfe_pkg::CFG_IN_ARCS:  max_in_reg  <= cfg_data[3:0];
                pnfe_pkg::CFG_OUT_ARCS: max_out_reg <= cfg_data[3:0];
                default: ;
            endcase
        end
    end

    // clamped limits
    logic [pnfe_pkg::TW:0]   nt;
    logic [pnfe_pkg::PW:0]   np;
    logic [pnfe_pkg::FW-1:0] lim_in, lim_out;

    always_comb begin
        if (tcount_reg == 6'd0) nt = (pnfe_pkg::TW+1)'(1);
        else if (tcount_reg > 6'(pnfe_pkg::MAX_TRANS)) nt = (pnfe_pkg::TW+1)'(pnfe_pkg::MAX_TRANS);
        else nt = (pnfe_pkg::TW+1)'(tcount_reg);
        if (pcount_reg == 6'd0) np = (pnfe_pkg::PW+1)'(1);
        else if (pcount_reg > 6'(pnfe_pkg::MAX_PLACES)) np = (pnfe_pkg::PW+1)'(pnfe_pkg::MAX_PLACES);
        else np = (pnfe_pkg::PW+1)'(pcount_reg);
        if (max_in_reg == 4'd0) lim_in = pnfe_pkg::FW'(1);
        else if (max_in_reg > 4'(pnfe_pkg::ARC_SLOTS)) lim_in = pnfe_pkg::FW'(pnfe_pkg::ARC_SLOTS);
        else lim_in = pnfe_pkg::FW'(max_in_reg);
        if (max_out_reg == 4'd0) lim_out = pnfe_pkg::FW'(1);
        else if (max_out_reg > 4'(pnfe_pkg::ARC_SLOTS)) lim_out = pnfe_pkg::FW'(pnfe_pkg::ARC_SLOTS);
        else lim_out = pnfe_pkg::FW'(max_out_reg);
    end

    // request latch
    logic [3:0]                 kind_reg;
    logic [pnfe_pkg::TW-1:0]    item_t_reg;
    logic [pnfe_pkg::PW-1:0]    item_p_reg;
    logic                       to_out_reg;
    logic [pnfe_pkg::TOK_W-1:0] value_reg;

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            kind_reg   <= s_kind;
            item_t_reg <= s_transition;
            item_p_reg <= s_place;
            to_out_reg <= s_to_output;
            value_reg  <= s_value;
        end
    end

    logic vec, single;
    assign vec    = (kind_reg == pnfe_pkg::KIND_FIRE_VEC) ||
                    (kind_reg == pnfe_pkg::KIND_CHECK_VEC);
    assign single = (kind_reg == pnfe_pkg::KIND_FIRE_ONE) ||
                    (kind_reg == pnfe_pkg::KIND_CHECK_ONE);

    // loop counters
    logic [pnfe_pkg::TW-1:0] t_idx_reg;
    logic [pnfe_pkg::FW-1:0] s_cnt_reg;
    logic [pnfe_pkg::PW-1:0] p_idx_reg;

    always_ff @(posedge aclk) begin
        if (cmd.t_init) t_idx_reg <= vec ? '0 : item_t_reg;
        else if (cmd.t_inc) t_idx_reg <= t_idx_reg + 1'b1;
        if (cmd.s_clr) s_cnt_reg <= '0;
        else if (cmd.s_inc) s_cnt_reg <= s_cnt_reg + 1'b1;
        if (cmd.p_clr) p_idx_reg <= '0;
        else if (cmd.p_inc) p_idx_reg <= p_idx_reg + 1'b1;
    end

    // per-transition state
    logic [pnfe_pkg::TOK_W-1:0] fq_reg   [pnfe_pkg::MAX_TRANS];
    logic                       cond_reg [pnfe_pkg::MAX_TRANS];
    logic [pnfe_pkg::FW-1:0]    in_fill_reg  [pnfe_pkg::MAX_TRANS];
    logic [pnfe_pkg::FW-1:0]    out_fill_reg [pnfe_pkg::MAX_TRANS];

    logic [pnfe_pkg::FW-1:0]    used_in, used_out, used_sel, lim_sel;
    logic [pnfe_pkg::TOK_W-1:0] q;

    assign used_in  = (in_fill_reg[t_idx_reg]  < lim_in)  ? in_fill_reg[t_idx_reg]  : lim_in;
    assign used_out = (out_fill_reg[t_idx_reg] < lim_out) ? out_fill_reg[t_idx_reg] : lim_out;
    assign used_sel = to_out_reg ? used_out : used_in;
    assign lim_sel  = to_out_reg ? lim_out : lim_in;
    assign q        = single ? pnfe_pkg::TOK_W'(1) : fq_reg[t_idx_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < pnfe_pkg::MAX_TRANS; i++) begin
                fq_reg[i]       <= '0;
                cond_reg[i]     <= 1'b1;
                in_fill_reg[i]  <= '0;
                out_fill_reg[i] <= '0;
            end
        end else begin
            if (cmd.clr_fill) begin
                for (int i = 0; i < pnfe_pkg::MAX_TRANS; i++) begin
                    in_fill_reg[i]  <= '0;
                    out_fill_reg[i] <= '0;
                end
            end
            if (cmd.wr_simple && stat.t_ok) begin
                if (kind_reg == pnfe_pkg::KIND_COND) cond_reg[item_t_reg] <= value_reg[0];
                if (kind_reg == pnfe_pkg::KIND_QTY)  fq_reg[item_t_reg]   <= value_reg;
            end
            if (cmd.wr_arc) begin
                if (to_out_reg) out_fill_reg[t_idx_reg] <= used_out + 1'b1;
                else in_fill_reg[t_idx_reg] <= used_in + 1'b1;
            end
        end
    end

    // arc memories
    logic [pnfe_pkg::PW-1:0] in_mem  [pnfe_pkg::ARC_DEPTH];
    logic [pnfe_pkg::PW-1:0] out_mem [pnfe_pkg::ARC_DEPTH];
    logic [pnfe_pkg::PW-1:0] in_rdata_reg, out_rdata_reg;
    logic [pnfe_pkg::AW-1:0] rd_addr, wr_addr;

    assign rd_addr = {t_idx_reg, s_cnt_reg[pnfe_pkg::SW-1:0]};
    assign wr_addr = {t_idx_reg, used_sel[pnfe_pkg::SW-1:0]};

    always_ff @(posedge aclk) begin
        if (cmd.wr_arc && !to_out_reg) in_mem[wr_addr] <= item_p_reg;
        if (cmd.rd_in) in_rdata_reg <= in_mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (cmd.wr_arc && to_out_reg) out_mem[wr_addr] <= item_p_reg;
        if (cmd.rd_out) out_rdata_reg <= out_mem[rd_addr];
    end

    // tokens and demand
    logic [pnfe_pkg::TOK_W-1:0] tok_reg [pnfe_pkg::MAX_PLACES];
    logic [pnfe_pkg::DEM_W-1:0] dem_reg [pnfe_pkg::MAX_PLACES];
    logic [pnfe_pkg::PW-1:0]    tok_addr, dem_addr;
    logic [pnfe_pkg::TOK_W-1:0] tok_rd;
    logic [pnfe_pkg::DEM_W-1:0] dem_rd;

    always_comb begin
        if (cmd.add_tok) tok_addr = out_rdata_reg;
        else if (cmd.rd_tok || cmd.wr_simple) tok_addr = item_p_reg;
        else tok_addr = p_idx_reg;
    end
    assign dem_addr = cmd.acc_demand ? in_rdata_reg : p_idx_reg;
    assign tok_rd   = tok_reg[tok_addr];
    assign dem_rd   = dem_reg[dem_addr];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < pnfe_pkg::MAX_PLACES; i++) tok_reg[i] <= '0;
        end else if (cmd.wr_simple && stat.p_ok && kind_reg == pnfe_pkg::KIND_TOKENS) begin
            tok_reg[tok_addr] <= value_reg;
        end else if (cmd.sub_tok) begin
            tok_reg[tok_addr] <= tok_rd - dem_rd[pnfe_pkg::TOK_W-1:0];
        end else if (cmd.add_tok) begin
            tok_reg[tok_addr] <= tok_rd + q;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.clr_demand) begin
            for (int i = 0; i < pnfe_pkg::MAX_PLACES; i++) dem_reg[i] <= '0;
        end else if (cmd.acc_demand) begin
            dem_reg[dem_addr] <= dem_rd + pnfe_pkg::DEM_W'(q);
        end
    end

    // result register
    logic [1:0]                 status_reg;
    logic [pnfe_pkg::TOK_W-1:0] count_reg;
    logic                       m_valid_reg;
    logic [1:0]                 m_status_reg;
    logic [pnfe_pkg::TOK_W-1:0] m_count_reg;

    always_ff @(posedge aclk) begin
        if (cmd.load) count_reg <= '0;
        else if (cmd.rd_tok && stat.p_ok) count_reg <= tok_rd;
        if (cmd.set_status) status_reg <= cmd.status;
        if (cmd.emit) begin
            m_status_reg <= status_reg;
            m_count_reg  <= count_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.emit) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_status      = m_status_reg;
    assign m_token_count = m_count_reg;

    // status to the controller
    logic [pnfe_pkg::PW-1:0] sel_rdata;
    logic [pnfe_pkg::TW-1:0] t_hi;

    assign sel_rdata = to_out_reg ? out_rdata_reg : in_rdata_reg;
    assign t_hi      = single ? item_t_reg : pnfe_pkg::TW'(nt - 1'b1);

    always_comb begin
        stat.kind      = pnfe_pkg::kind_t'(kind_reg);
        stat.t_ok      = ({1'b0, item_t_reg} < nt);
        stat.p_ok      = ({1'b0, item_p_reg} < np);
        stat.to_out    = to_out_reg;
        stat.commit    = (kind_reg == pnfe_pkg::KIND_FIRE_VEC) ||
                         (kind_reg == pnfe_pkg::KIND_FIRE_ONE);
        stat.q_zero    = (q == '0);
        stat.cond_bad  = (q != '0) && cen_reg && !cond_reg[t_idx_reg];
        stat.t_last    = (t_idx_reg == t_hi);
        stat.in_end    = (s_cnt_reg >= used_in);
        stat.out_end   = (s_cnt_reg >= used_out);
        stat.sel_end   = (s_cnt_reg >= used_sel);
        stat.sel_full  = (used_sel >= lim_sel);
        stat.dup       = (sel_rdata == item_p_reg);
        stat.tok_short = (pnfe_pkg::DEM_W'(tok_reg[p_idx_reg]) < dem_reg[p_idx_reg]);
        stat.p_last    = (p_idx_reg == pnfe_pkg::PW'(pnfe_pkg::MAX_PLACES - 1));
        stat.out_busy  = m_valid_reg && !m_ready;
    end

    // a list is never written past its limit
    a_arc_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.wr_arc |-> (used_sel < lim_sel))
        else $error("arc written into a full list");

    // tokens are only drawn down once every place has covered its demand
    a_sub_covered: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.sub_tok |-> !stat.tok_short)
        else $error("token draw-down exceeds demand check");

    // a new result never overwrites one still waiting
    a_emit_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |-> !(m_valid_reg && !m_ready))
        else $error("result overwritten while held");

endmodule

// File: sv/petri_net_firing_engine.sv
// Top level of the Petri net firing engine: joins controller and datapath.
// Depends on pnfe_pkg, pnfe_ctrl and pnfe_dp.
//
// One request in, one result out. Writes, reads and clears go straight
// from dispatch to done. Add arc walks the chosen list, reading and
// comparing each stored arc. A fire or check walks the transitions once
// for conditions, then the input arcs of each transition, then all 32
// places for the token test. A fire then draws down all 32 places and
// walks the output arcs of each transition. The arc memories give
// registered read data. A new request is taken once the previous result
// has entered the output register; no clearing pass is needed after reset.
module petri_net_firing_engine (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [2:0]                  cfg_index,
    input  logic [15:0]                 cfg_data,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [3:0]                  s_kind,
    input  logic [pnfe_pkg::TW-1:0]     s_transition,
    input  logic [pnfe_pkg::PW-1:0]     s_place,
    input  logic                        s_to_output,
    input  logic [pnfe_pkg::TOK_W-1:0]  s_value,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [1:0]                  m_status,
    output logic [pnfe_pkg::TOK_W-1:0]  m_token_count
);

    pnfe_pkg::cmd_t  cmd;
    pnfe_pkg::stat_t stat;

    // sequence each request
    pnfe_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    // hold the net and do the arithmetic
    pnfe_dp u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_kind        (s_kind),
        .s_transition  (s_transition),
        .s_place       (s_place),
        .s_to_output   (s_to_output),
        .s_value       (s_value),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_status      (m_status),
        .m_token_count (m_token_count),
        .cmd           (cmd),
        .stat          (stat)
    );

endmodule

// File: tb/sv/tb.sv
// Self-checking bench for the Petri net firing engine: drives commands, predicts
// every status and token count, and compares them with the block's results.
// Depends on pnfe_pkg and petri_net_firing_engine.
module tb;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = '0;
    logic [15:0] cfg_data = '0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [3:0]  s_kind = '0;
    logic [4:0]  s_transition = '0;
    logic [4:0]  s_place = '0;
    logic        s_to_output = 1'b0;
    logic [15:0] s_value = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [1:0]  m_status;
    logic [15:0] m_token_count;

    petri_net_firing_engine dut (.*);

    always #5 aclk = ~aclk;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] count;
    } reply_t;

    // Predictor state
    logic        pn_cond_en;
    logic [5:0]  pn_places, pn_trans;
    logic [3:0]  pn_in_lim, pn_out_lim;
    logic [15:0] pn_tok [32];
    logic [15:0] pn_qty [32];
    logic [4:0]  pn_in [32][8];
    logic [4:0]  pn_out [32][8];
    int          pn_in_fill [32];
    int          pn_out_fill [32];
    logic        pn_cbit [32];

    reply_t replies_due [$];
    int     mismatches = 0;
    bit     hold_off = 1'b0;
    int     stall_pct = 30;

    function automatic int clampv(int v, int hi);
        if (v < 1) return 1;
        return (v > hi) ? hi : v;
    endfunction

    function automatic logic [1:0] fire_net(int lo, int hi, bit single, bit commit);
        int demand [32];
        int q, n;
        for (int p = 0; p < 32; p++) demand[p] = 0;
        for (int t = lo; t < hi; t++) begin
            q = single ? 1 : pn_qty[t];
            if (q != 0 && pn_cond_en && !pn_cbit[t]) return pnfe_pkg::ST_COND;
        end
        for (int t = lo; t < hi; t++) begin
            q = single ? 1 : pn_qty[t];
            n = pn_in_fill[t] < clampv(pn_in_lim, 8) ? pn_in_fill[t] : clampv(pn_in_lim, 8);
            if (q != 0)
                for (int i = 0; i < n; i++) demand[pn_in[t][i]] += q;
        end
        for (int p = 0; p < 32; p++)
            if (pn_tok[p] < demand[p]) return pnfe_pkg::ST_TOKENS;
        if (!commit) return pnfe_pkg::ST_OK;
        for (int p = 0; p < 32; p++) pn_tok[p] = pn_tok[p] - demand[p][15:0];
        for (int t = lo; t < hi; t++) begin
            q = single ? 1 : pn_qty[t];
            n = pn_out_fill[t] < clampv(pn_out_lim, 8) ? pn_out_fill[t]
                                                        : clampv(pn_out_lim, 8);
            for (int i = 0; i < n; i++)
                pn_tok[pn_out[t][i]] = pn_tok[pn_out[t][i]] + q[15:0];
        end
        return pnfe_pkg::ST_OK;
    endfunction

    function automatic reply_t predict_reply(logic [3:0] k, int t, int p, bit o,
                                             logic [15:0] v);
        reply_t r;
        int np, nt, lim, n;
        bit t_ok, p_ok;
        r = '0;
        np = clampv(pn_places, 32);
        nt = clampv(pn_trans, 32);
        t_ok = t < nt;
        p_ok = p < np;
        case (k)
            pnfe_pkg::KIND_CLEAR: begin
                for (int i = 0; i < 32; i++) begin
                    pn_in_fill[i] = 0;
                    pn_out_fill[i] = 0;
                end
            end
            pnfe_pkg::KIND_ADD_ARC: begin
                if (!(t_ok && p_ok)) r.status = pnfe_pkg::ST_RANGE;
                else begin
                    lim = clampv(o ? pn_out_lim : pn_in_lim, 8);
                    n = o ? pn_out_fill[t] : pn_in_fill[t];
                    if (n > lim) n = lim;
                    for (int i = 0; i < n; i++)
                        if ((o ? pn_out[t][i] : pn_in[t][i]) == p)
                            r.status = pnfe_pkg::ST_RANGE;
                    if (n >= lim) r.status = pnfe_pkg::ST_RANGE;
                    if (r.status == pnfe_pkg::ST_OK) begin
                        if (o) begin
                            pn_out[t][n] = p[4:0];
                            pn_out_fill[t] = n + 1;
                        end else begin
                            pn_in[t][n] = p[4:0];
                            pn_in_fill[t] = n + 1;
                        end
                    end
                end
            end
            pnfe_pkg::KIND_TOKENS:
                if (p_ok) pn_tok[p] = v; else r.status = pnfe_pkg::ST_RANGE;
            pnfe_pkg::KIND_COND:
                if (t_ok) pn_cbit[t] = v[0]; else r.status = pnfe_pkg::ST_RANGE;
            pnfe_pkg::KIND_QTY:
                if (t_ok) pn_qty[t] = v; else r.status = pnfe_pkg::ST_RANGE;
            pnfe_pkg::KIND_FIRE_VEC:  r.status = fire_net(0, nt, 0, 1);
            pnfe_pkg::KIND_CHECK_VEC: r.status = fire_net(0, nt, 0, 0);
            pnfe_pkg::KIND_FIRE_ONE:
                r.status = t_ok ? fire_net(t, t + 1, 1, 1) : pnfe_pkg::ST_RANGE;
            pnfe_pkg::KIND_CHECK_ONE:
                r.status = t_ok ? fire_net(t, t + 1, 1, 0) : pnfe_pkg::ST_RANGE;
            pnfe_pkg::KIND_READ:
                if (p_ok) r.count = pn_tok[p]; else r.status = pnfe_pkg::ST_RANGE;
            default: r.status = pnfe_pkg::ST_RANGE;
        endcase
        return r;
    endfunction

    // Send one request; prediction is made at the accepting edge. Valid drops
    // afterwards, while the block is still busy with the request.
    task automatic send_request(logic [3:0] k, int t, int p, bit o, logic [15:0] v);
        s_valid <= 1'b1;
        s_kind <= k;
        s_transition <= t[4:0];
        s_place <= p[4:0];
        s_to_output <= o;
        s_value <= v;
        do @(posedge aclk); while (!s_ready);
        replies_due.push_back(predict_reply(k, t, p, o, v));
        @(negedge aclk);
        s_valid <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic drain();
        while (replies_due.size() != 0) @(negedge aclk);
        repeat (50) @(negedge aclk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [15:0] d);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= d;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            pnfe_pkg::CFG_COND_EN:  pn_cond_en = d[0];
            pnfe_pkg::CFG_PLACES:   pn_places = d[5:0];
            pnfe_pkg::CFG_TRANS:    pn_trans = d[5:0];
            pnfe_pkg::CFG_IN_ARCS:  pn_in_lim = d[3:0];
            pnfe_pkg::CFG_OUT_ARCS: pn_out_lim = d[3:0];
            default: ;
        endcase
        @(negedge aclk);
        cfg_valid <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic set_all(bit c, int np, int nt, int ni, int no);
        drain();
        write_reg(pnfe_pkg::CFG_COND_EN, {15'd0, c});
        write_reg(pnfe_pkg::CFG_PLACES, np[15:0]);
        write_reg(pnfe_pkg::CFG_TRANS, nt[15:0]);
        write_reg(pnfe_pkg::CFG_IN_ARCS, ni[15:0]);
        write_reg(pnfe_pkg::CFG_OUT_ARCS, no[15:0]);
    endtask

    // Bursty random gap between requests
    int burst_left = 0;
    task automatic pace();
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            repeat ($urandom_range(0, 6)) @(negedge aclk);
        end
        burst_left--;
    endtask

    // Receiver stall pattern
    always @(negedge aclk) begin
        if (!aresetn || hold_off) m_ready <= 1'b0;
        else m_ready <= ($urandom_range(0, 99) >= stall_pct);
    end

    // Result checker
    always @(posedge aclk) begin
        reply_t want;
        if (aresetn && m_valid && m_ready) begin
            if (replies_due.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result status=%0d", m_status);
            end else begin
                want = replies_due.pop_front();
                if (m_status !== want.status || m_token_count !== want.count) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result: status exp %0d got %0d, tokens exp %0d got %0d",
                                 want.status, m_status, want.count, m_token_count);
                end
            end
        end
    end

    task automatic test_directed();
        send_request(pnfe_pkg::KIND_READ, 0, 0, 0, 0);
        send_request(pnfe_pkg::KIND_TOKENS, 0, 0, 0, 16'hFFFF);
        send_request(pnfe_pkg::KIND_TOKENS, 0, 31, 0, 16'd3);
        send_request(pnfe_pkg::KIND_ADD_ARC, 0, 0, 0, 0);
        send_request(pnfe_pkg::KIND_ADD_ARC, 0, 0, 0, 0);       // duplicate
        send_request(pnfe_pkg::KIND_ADD_ARC, 0, 0, 1, 0);       // self loop
        send_request(pnfe_pkg::KIND_ADD_ARC, 31, 31, 0, 0);
        send_request(pnfe_pkg::KIND_ADD_ARC, 31, 1, 1, 0);
        send_request(pnfe_pkg::KIND_FIRE_ONE, 0, 0, 0, 0);
        send_request(pnfe_pkg::KIND_READ, 0, 0, 0, 0);
        send_request(pnfe_pkg::KIND_CHECK_ONE, 31, 0, 0, 0);
        send_request(pnfe_pkg::KIND_QTY, 31, 0, 0, 16'd4);      // demand beyond stock
        send_request(pnfe_pkg::KIND_CHECK_VEC, 0, 0, 0, 0);
        send_request(pnfe_pkg::KIND_FIRE_VEC, 0, 0, 0, 0);
        send_request(pnfe_pkg::KIND_QTY, 31, 0, 0, 16'd3);
        send_request(pnfe_pkg::KIND_FIRE_VEC, 0, 0, 0, 0);
        send_request(pnfe_pkg::KIND_READ, 0, 1, 0, 0);
        send_request(pnfe_pkg::KIND_COND, 31, 0, 0, 16'hFFFE);
        send_request(pnfe_pkg::KIND_FIRE_ONE, 31, 0, 0, 0);
        send_request(4'd10, 0, 0, 0, 0);
        send_request(4'd15, 31, 31, 1, 16'hFFFF);
        send_request(pnfe_pkg::KIND_CLEAR, 0, 0, 0, 0);
        send_request(pnfe_pkg::KIND_FIRE_VEC, 0, 0, 0, 0);
        // conditions on, false bit on transition 31
        set_all(1, 32, 32, 8, 8);
        send_request(pnfe_pkg::KIND_FIRE_ONE, 31, 0, 0, 0);
        send_request(pnfe_pkg::KIND_CHECK_VEC, 0, 0, 0, 0);
    endtask

    // Fill one transition's lists to the brim to exercise full-list rejection
    task automatic test_full_lists();
        for (int i = 0; i < 10; i++) send_request(pnfe_pkg::KIND_ADD_ARC, 2, i, 0, 0);
        for (int i = 0; i < 10; i++) send_request(pnfe_pkg::KIND_ADD_ARC, 2, 31 - i, 1, 0);
    endtask

    task automatic random_item(int nt, int np);
        int r, t, p;
        logic [3:0] k;
        logic [15:0] v;
        r = $urandom_range(0, 99);
        t = $urandom_range(0, 99) < 90 ? $urandom_range(0, nt) : $urandom_range(0, 31);
        p = $urandom_range(0, 99) < 90 ? $urandom_range(0, np) : $urandom_range(0, 31);
        v = $urandom_range(0, 3) == 0 ? 16'($urandom) : 16'($urandom_range(0, 12));
        if      (r < 2)  k = pnfe_pkg::KIND_CLEAR;
        else if (r < 25) k = pnfe_pkg::KIND_ADD_ARC;
        else if (r < 40) k = pnfe_pkg::KIND_TOKENS;
        else if (r < 46) k = pnfe_pkg::KIND_COND;
        else if (r < 54) begin
            k = pnfe_pkg::KIND_QTY;
            v = $urandom_range(0, 9) == 0 ? 16'($urandom) : 16'($urandom_range(0, 3));
        end
        else if (r < 62) k = pnfe_pkg::KIND_FIRE_VEC;
        else if (r < 67) k = pnfe_pkg::KIND_CHECK_VEC;
        else if (r < 80) k = pnfe_pkg::KIND_FIRE_ONE;
        else if (r < 85) k = pnfe_pkg::KIND_CHECK_ONE;
        else if (r < 98) k = pnfe_pkg::KIND_READ;
        else k = 4'($urandom_range(10, 15));
        pace();
        send_request(k, t, p, 1'($urandom_range(0, 1)), v);
    endtask

    task automatic test_random(int count, int nt, int np);
        for (int i = 0; i < count; i++) random_item(nt, np);
    endtask

    // Hold the receiver off while requests keep coming
    task automatic test_backpressure();
        fork
            begin
                hold_off = 1'b1;
                repeat (300) @(negedge aclk);
                hold_off = 1'b0;
            end
            test_random(20, 7, 7);
        join
        drain();
    endtask

    task automatic test_settings();
        set_all(0, 8, 6, 3, 2);
        test_random(80, 7, 9);
        set_all(1, 1, 1, 1, 1);
        test_random(40, 1, 1);
        set_all(1, 32, 32, 8, 8);
        stall_pct = 0;
        test_random(80, 31, 31);
        stall_pct = 60;
        set_all(0, 0, 63, 0, 15);       // out of range values clamp
        test_random(40, 31, 31);
        set_all(0, 12, 10, 2, 8);       // lowered arc limit
        test_random(60, 11, 13);
        stall_pct = 30;
        set_all(0, 4, 32, 8, 4);        // shrunk place count
        test_random(60, 31, 5);
    endtask

    initial begin
        pn_cond_en = 0;
        pn_places = 32;
        pn_trans = 32;
        pn_in_lim = 8;
        pn_out_lim = 8;
        for (int i = 0; i < 32; i++) begin
            pn_tok[i] = 0;
            pn_qty[i] = 0;
            pn_in_fill[i] = 0;
            pn_out_fill[i] = 0;
            pn_cbit[i] = 1;
        end
        repeat (5) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        test_directed();
        test_full_lists();
        test_backpressure();
        test_settings();
        drain();
        if (mismatches == 0) $display("SCOREBOARD CLEAN");
        else $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        #20000000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule
